[rtl/core/pfc_pkg.sv]
// Pixel format converter package: format codes, item types and byte counts.
// Used by every module of the pixel format converter; depends on nothing.

package pfc_pkg;

  // Format codes, shared by the source and destination registers
  localparam logic [3:0] FMT_A8        = 4'd0;
  localparam logic [3:0] FMT_R8        = 4'd1;
  localparam logic [3:0] FMT_G8        = 4'd2;
  localparam logic [3:0] FMT_B8        = 4'd3;
  localparam logic [3:0] FMT_RGB888    = 4'd4;
  localparam logic [3:0] FMT_RGBA8888  = 4'd5;
  localparam logic [3:0] FMT_ARGB8888  = 4'd6;
  localparam logic [3:0] FMT_BGR888    = 4'd7;
  localparam logic [3:0] FMT_BGRA8888  = 4'd8;
  localparam logic [3:0] FMT_ABGR8888  = 4'd9;
  localparam logic [3:0] FMT_RGBA5551  = 4'd10;
  localparam logic [3:0] FMT_RGBX5551  = 4'd11;
  localparam logic [3:0] FMT_ARGB1555  = 4'd12;
  localparam logic [3:0] FMT_XRGB1555  = 4'd13;
  localparam logic [3:0] FMT_RGB565_BE = 4'd14;
  localparam logic [3:0] FMT_RGB565_LE = 4'd15;

  localparam logic [3:0] FMT_RESET = FMT_ARGB8888;

  // Register indexes on the APB port (word index = paddr[2])
  localparam logic REG_SRC_FORMAT = 1'b0;
  localparam logic REG_DST_FORMAT = 1'b1;

  // Destination byte counts
  localparam logic [2:0] CNT_ONE   = 3'd1;
  localparam logic [2:0] CNT_TWO   = 3'd2;
  localparam logic [2:0] CNT_THREE = 3'd3;
  localparam logic [2:0] CNT_FOUR  = 3'd4;

  // Raw source pixel, bytes in memory order
  typedef struct packed {
    logic [7:0] in_byte0;
    logic [7:0] in_byte1;
    logic [7:0] in_byte2;
    logic [7:0] in_byte3;
  } pfc_in_t;

  // Packed destination pixel and its byte count
  typedef struct packed {
    logic [7:0] out_byte0;
    logic [7:0] out_byte1;
    logic [7:0] out_byte2;
    logic [7:0] out_byte3;
    logic [2:0] out_count;
  } pfc_out_t;

  // Internal channel set between unpack and pack
  typedef struct packed {
    logic [7:0] a;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } pfc_argb_t;

endpackage

[rtl/core/pfc_unpack.sv]
// Pixel format converter source unpacker: raw bytes to alpha, red, green, blue.
// Combinational; depends on pfc_pkg.

module pfc_unpack
  import pfc_pkg::*;
(
  input  logic [3:0] fmt,
  input  pfc_in_t    pix,
  output pfc_argb_t  argb
);

  logic [15:0] word_be;
  logic [15:0] word_565;

  assign word_be  = {pix.in_byte0, pix.in_byte1};
  assign word_565 = (fmt == FMT_RGB565_LE) ? {pix.in_byte1, pix.in_byte0} : word_be;

  // Spread the source fields; missing colors are zero, missing alpha is opaque
  always_comb begin
    argb = '{a: 8'hff, r: 8'h00, g: 8'h00, b: 8'h00};
    case (fmt)
      FMT_A8: begin
        argb.a = pix.in_byte0;
      end
      FMT_R8: begin
        argb.r = pix.in_byte0;
      end
      FMT_G8: begin
        argb.g = pix.in_byte0;
      end
      FMT_B8: begin
        argb.b = pix.in_byte0;
      end
      FMT_RGB888: begin
        argb.r = pix.in_byte0;
        argb.g = pix.in_byte1;
        argb.b = pix.in_byte2;
      end
      FMT_RGBA8888: begin
        argb.r = pix.in_byte0;
        argb.g = pix.in_byte1;
        argb.b = pix.in_byte2;
        argb.a = pix.in_byte3;
      end
      FMT_ARGB8888: begin
        argb.a = pix.in_byte0;
        argb.r = pix.in_byte1;
        argb.g = pix.in_byte2;
        argb.b = pix.in_byte3;
      end
      FMT_BGR888: begin
        argb.b = pix.in_byte0;
        argb.g = pix.in_byte1;
        argb.r = pix.in_byte2;
      end
      FMT_BGRA8888: begin
        argb.b = pix.in_byte0;
        argb.g = pix.in_byte1;
        argb.r = pix.in_byte2;
        argb.a = pix.in_byte3;
      end
      FMT_ABGR8888: begin
        argb.a = pix.in_byte0;
        argb.b = pix.in_byte1;
        argb.g = pix.in_byte2;
        argb.r = pix.in_byte3;
      end
      FMT_RGBA5551, FMT_RGBX5551: begin
        argb.r = {word_be[15:11], 3'b000};
        argb.g = {word_be[10:6], 3'b000};
        argb.b = {word_be[5:1], 3'b000};
        // Padding bit reads as opaque
        if (fmt == FMT_RGBA5551) begin
          argb.a = {8{word_be[0]}};
        end
      end
      FMT_ARGB1555, FMT_XRGB1555: begin
        argb.r = {word_be[14:10], 3'b000};
        argb.g = {word_be[9:5], 3'b000};
        argb.b = {word_be[4:0], 3'b000};
        if (fmt == FMT_ARGB1555) begin
          argb.a = {8{word_be[15]}};
        end
      end
      default: begin
        // Both 565 layouts, byte order already resolved
        argb.r = {word_565[15:11], 3'b000};
        argb.g = {word_565[10:5], 2'b00};
        argb.b = {word_565[4:0], 3'b000};
      end
    endcase
  end

endmodule

[rtl/core/pfc_pack.sv]
// Pixel format converter destination packer: channel set to packed bytes.
// Combinational; depends on pfc_pkg.

module pfc_pack
  import pfc_pkg::*;
(
  input  logic [3:0] fmt,
  input  pfc_argb_t  argb,
  output pfc_out_t   pix
);

  logic        abit;
  logic [15:0] w5551;
  logic [15:0] w1555;
  logic [15:0] w565;

  assign abit  = (argb.a != 8'h00);
  assign w5551 = {argb.r[7:3], argb.g[7:3], argb.b[7:3], abit & (fmt == FMT_RGBA5551)};
  assign w1555 = {abit & (fmt == FMT_ARGB1555), argb.r[7:3], argb.g[7:3], argb.b[7:3]};
  assign w565  = {argb.r[7:3], argb.g[7:2], argb.b[7:3]};

  // Place channels in memory order; unused bytes stay zero
  always_comb begin
    pix = '0;
    case (fmt)
      FMT_A8: begin
        pix.out_byte0 = argb.a;
        pix.out_count = CNT_ONE;
      end
      FMT_R8: begin
        pix.out_byte0 = argb.r;
        pix.out_count = CNT_ONE;
      end
      FMT_G8: begin
        pix.out_byte0 = argb.g;
        pix.out_count = CNT_ONE;
      end
      FMT_B8: begin
        pix.out_byte0 = argb.b;
        pix.out_count = CNT_ONE;
      end
      FMT_RGB888: begin
        pix.out_byte0 = argb.r;
        pix.out_byte1 = argb.g;
        pix.out_byte2 = argb.b;
        pix.out_count = CNT_THREE;
      end
      FMT_RGBA8888: begin
        pix.out_byte0 = argb.r;
        pix.out_byte1 = argb.g;
        pix.out_byte2 = argb.b;
        pix.out_byte3 = argb.a;
        pix.out_count = CNT_FOUR;
      end
      FMT_ARGB8888: begin
        pix.out_byte0 = argb.a;
        pix.out_byte1 = argb.r;
        pix.out_byte2 = argb.g;
        pix.out_byte3 = argb.b;
        pix.out_count = CNT_FOUR;
      end
      FMT_BGR888: begin
        pix.out_byte0 = argb.b;
        pix.out_byte1 = argb.g;
        pix.out_byte2 = argb.r;
        pix.out_count = CNT_THREE;
      end
      FMT_BGRA8888: begin
        pix.out_byte0 = argb.b;
        pix.out_byte1 = argb.g;
        pix.out_byte2 = argb.r;
        pix.out_byte3 = argb.a;
        pix.out_count = CNT_FOUR;
      end
      FMT_ABGR8888: begin
        pix.out_byte0 = argb.a;
        pix.out_byte1 = argb.b;
        pix.out_byte2 = argb.g;
        pix.out_byte3 = argb.r;
        pix.out_count = CNT_FOUR;
      end
      FMT_RGBA5551, FMT_RGBX5551: begin
        pix.out_byte0 = w5551[15:8];
        pix.out_byte1 = w5551[7:0];
        pix.out_count = CNT_TWO;
      end
      FMT_ARGB1555, FMT_XRGB1555: begin
        pix.out_byte0 = w1555[15:8];
        pix.out_byte1 = w1555[7:0];
        pix.out_count = CNT_TWO;
      end
      FMT_RGB565_LE: begin
        pix.out_byte0 = w565[7:0];
        pix.out_byte1 = w565[15:8];
        pix.out_count = CNT_TWO;
      end
      default: begin
        // Big-endian 565
        pix.out_byte0 = w565[15:8];
        pix.out_byte1 = w565[7:0];
        pix.out_count = CNT_TWO;
      end
    endcase
  end

endmodule

[rtl/core/pixel_format_converter_unit.sv]
// Pixel format converter top level: APB registers, input and result registers.
// Depends on pfc_pkg, pfc_unpack and pfc_pack.
//
//   channel  | signals                          | payload
//   ---------+----------------------------------+----------------------------
//   source   | src_valid, src_stall             | src_item (pfc_in_t)
//   result   | dst_valid, dst_stall             | dst_item (pfc_out_t)
//   config   | psel, penable, pwrite, paddr ... | src_format @0, dst_format @4
//
// One item per cycle sustained while dst_stall is low; each item passes the input
// register, then the result register, with unpack and pack between them.
// Reset clears both valid flags and sets both formats to argb8888.
// A stalled result holds in the result register while the input register
// still takes one more item; src_stall rises only when both are full.

module pixel_format_converter_unit
  import pfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // APB register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Source pixels
  input  logic        src_valid,
  output logic        src_stall,
  input  pfc_in_t     src_item,
  // Converted pixels
  output logic        dst_valid,
  input  logic        dst_stall,
  output pfc_out_t    dst_item
);

  logic [3:0] src_format;
  logic [3:0] dst_format;
  logic       cfg_write;

  logic       s1_valid;
  pfc_in_t    s1_item;
  logic       src_take;
  logic       out_move;

  pfc_argb_t  argb;
  pfc_out_t   conv;

  // Register writes complete on the access cycle
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_format <= FMT_RESET;
      dst_format <= FMT_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == REG_SRC_FORMAT) begin
        src_format <= pwdata[3:0];
      end else begin
        dst_format <= pwdata[3:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_SRC_FORMAT) ? {28'd0, src_format} : {28'd0, dst_format};

  // Advance the result register when it is empty or being taken
  assign out_move  = ~dst_valid | ~dst_stall;
  assign src_stall = s1_valid & ~out_move;
  assign src_take  = src_valid & ~src_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (src_take) begin
      s1_valid <= 1'b1;
    end else if (out_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (src_take) begin
      s1_item <= src_item;
    end
  end

  pfc_unpack u_unpack (
    .fmt  (src_format),
    .pix  (s1_item),
    .argb (argb)
  );

  pfc_pack u_pack (
    .fmt  (dst_format),
    .argb (argb),
    .pix  (conv)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (out_move) begin
      dst_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_move && s1_valid) begin
      dst_item <= conv;
    end
  end

endmodule

[rtl/core/pfc_checker.sv]
// Pixel format converter port checker and its bind to the top level.
// Depends on pfc_pkg and pixel_format_converter_unit.

module pfc_checker
  import pfc_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     src_stall,
  input logic     dst_valid,
  input logic     dst_stall,
  input pfc_out_t dst_item
);

  // Reset empties the result side
  a_reset_empty: assert property (@(posedge clk) rst |=> !dst_valid)
    else $error("result valid after reset");

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    dst_valid && dst_stall |=> dst_valid && $stable(dst_item))
    else $error("stalled result changed");

  // An empty result register never backs up the source
  a_no_stall_empty: assert property (@(posedge clk) disable iff (rst)
    !dst_valid |-> !src_stall)
    else $error("source stalled with empty result register");

  // Byte count is one to four
  a_count: assert property (@(posedge clk) disable iff (rst)
    dst_valid |-> (dst_item.out_count == CNT_ONE) || (dst_item.out_count == CNT_TWO) ||
                  (dst_item.out_count == CNT_THREE) || (dst_item.out_count == CNT_FOUR))
    else $error("bad byte count");

  // Bytes beyond the count are zero
  a_unused_zero: assert property (@(posedge clk) disable iff (rst)
    dst_valid |-> ((dst_item.out_count == CNT_FOUR) || (dst_item.out_byte3 == 8'h00)) &&
                  ((dst_item.out_count != CNT_ONE) && (dst_item.out_count != CNT_TWO) ||
                   (dst_item.out_byte2 == 8'h00)) &&
                  ((dst_item.out_count != CNT_ONE) || (dst_item.out_byte1 == 8'h00)))
    else $error("unused byte not zero");

endmodule

bind pixel_format_converter_unit pfc_checker u_pfc_checker (
  .clk       (clk),
  .rst       (rst),
  .src_stall (src_stall),
  .dst_valid (dst_valid),
  .dst_stall (dst_stall),
  .dst_item  (dst_item)
);
